// File: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// request and response payloads, codes, class tables, control structs
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int CFG_W   = 52;
    localparam int CLASS_W = 3;
    localparam int COUNT_W = 9;

    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [3:0]  HEADER_BYTES = 4'hC;

    // operation codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_REINIT = 2'd2;

    // response status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR = 2'd2;

    // configuration register indexes
    localparam logic CFG_SIZE_CLASS  = 1'b0;
    localparam logic CFG_PAGE_NUMBER = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] block_addr;
    } bba_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [63:0]        granted_addr;
        logic [COUNT_W-1:0] free_left;
    } bba_rsp_t;

    typedef struct packed {
        logic       ld_addr;
        logic       scan_start;
        logic       scan_step;
        logic       grant;
        logic       free_chk;
        logic       div_step;
        logic       free_rd;
        logic       free_wr;
        logic       fill_step;
        logic       res_load;
        logic       res_grant;
        logic [1:0] res_status;
    } bba_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_hit;
        logic scan_miss;
        logic page_ok;
        logic div_last;
        logic id_ok;
        logic fill_last;
    } bba_sts_t;

    // blocks per class in a 4 KiB page
    function automatic logic [COUNT_W-1:0] class_blocks(input logic [CLASS_W-1:0] c);
        logic [COUNT_W-1:0] r;
        unique case (c)
            3'd0: r = 9'd502;
            3'd1: r = 9'd253;
            3'd2: r = 9'd169;
            3'd3: r = 9'd127;
            3'd4: r = 9'd101;
            3'd5: r = 9'd84;
            3'd6: r = 9'd72;
            3'd7: r = 9'd63;
        endcase
        return r;
    endfunction

    // map words per class
    function automatic logic [4:0] class_words(input logic [CLASS_W-1:0] c);
        logic [4:0] r;
        unique case (c)
            3'd0: r = 5'd16;
            3'd1: r = 5'd8;
            3'd2: r = 5'd6;
            3'd3: r = 5'd4;
            3'd4: r = 5'd4;
            3'd5: r = 5'd3;
            3'd6: r = 5'd3;
            3'd7: r = 5'd2;
        endcase
        return r;
    endfunction

    // shift of the all-ones pattern for the last used word
    function automatic logic [4:0] class_tail_shift(input logic [CLASS_W-1:0] c);
        logic [4:0] r;
        unique case (c)
            3'd0: r = 5'd10;
            3'd1: r = 5'd3;
            3'd2: r = 5'd23;
            3'd3: r = 5'd1;
            3'd4: r = 5'd27;
            3'd5: r = 5'd12;
            3'd6: r = 5'd24;
            3'd7: r = 5'd1;
        endcase
        return r;
    endfunction

endpackage

// File: design/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl: allocator controller
// sequences map fill, allocate scan, free check and divide, response handshake
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [1:0]       req_op,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    input  bba_pkg::bba_sts_t sts,
    output bba_pkg::bba_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_INIT     = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_SCAN     = 9'b000000100,
        S_GRANT    = 9'b000001000,
        S_FREE_CHK = 9'b000010000,
        S_DIVIDE   = 9'b000100000,
        S_FREE_RD  = 9'b001000000,
        S_FREE_WR  = 9'b010000000,
        S_REINIT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   accept;

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.ld_addr = 1'b1;
                    priority if (req_op == bba_pkg::OP_ALLOC)
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = bba_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    else if (req_op == bba_pkg::OP_FREE)
                    begin
                        state_next = S_FREE_CHK;
                    end
                    else if (req_op == bba_pkg::OP_REINIT)
                    begin
                        state_next = S_REINIT;
                    end
                    else
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = bba_pkg::ST_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = S_GRANT;
                end
                else if (sts.scan_miss)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = bba_pkg::ST_FULL;
                    state_next     = S_IDLE;
                end
            end
            S_GRANT:
            begin
                cmd.grant      = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_grant  = 1'b1;
                cmd.res_status = bba_pkg::ST_DONE;
                state_next     = S_IDLE;
            end
            S_FREE_CHK:
            begin
                cmd.free_chk = 1'b1;
                if (sts.page_ok)
                begin
                    state_next = S_DIVIDE;
                end
                else
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = bba_pkg::ST_BAD_ADDR;
                    state_next     = S_IDLE;
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FREE_RD;
                end
            end
            S_FREE_RD:
            begin
                if (sts.id_ok)
                begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_FREE_WR;
                end
                else
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = bba_pkg::ST_BAD_ADDR;
                    state_next     = S_IDLE;
                end
            end
            S_FREE_WR:
            begin
                cmd.free_wr    = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = bba_pkg::ST_DONE;
                state_next     = S_IDLE;
            end
            S_REINIT:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = bba_pkg::ST_DONE;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// File: design/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp: allocator datapath
// config registers, free map memory, free count, divider, response register
// ----------------------------------------------------------------------------
module bba_dp #(
    parameter int PAGE_SHIFT = 12,
    parameter int MAP_WORDS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bba_pkg::bba_req_t         req,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [bba_pkg::CFG_W-1:0] cfg_data,
    input  bba_pkg::bba_cmd_t         cmd,
    output bba_pkg::bba_sts_t         sts,
    output bba_pkg::bba_rsp_t         rsp
);

    localparam int IDX_W = $clog2(MAP_WORDS);
    localparam int PTR_W = $clog2(MAP_WORDS + 1);
    localparam int QW    = PAGE_SHIFT - 3;
    localparam int DCW   = $clog2(QW);
    localparam int GW    = IDX_W + 5;
    localparam int CW    = bba_pkg::COUNT_W;

    function automatic logic [PTR_W-1:0] used_words(input logic [2:0] c);
        logic [4:0]       w;
        logic [PTR_W-1:0] r;
        w = bba_pkg::class_words(c);
        if (int'(w) > MAP_WORDS)
        begin
            r = PTR_W'(MAP_WORDS);
        end
        else
        begin
            r = PTR_W'(w);
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] eff_blocks(input logic [2:0] c);
        logic [CW-1:0] r;
        if (int'(bba_pkg::class_words(c)) > MAP_WORDS)
        begin
            r = CW'(MAP_WORDS * 32);
        end
        else
        begin
            r = bba_pkg::class_blocks(c);
        end
        return r;
    endfunction

    function automatic logic [31:0] valid_mask(input logic [2:0] c,
                                               input logic [PTR_W-1:0] word);
        logic [PTR_W-1:0] n;
        logic [31:0]      r;
        n = used_words(c);
        if (word >= n)
        begin
            r = '0;
        end
        else if ((word + PTR_W'(1) == n) && (int'(bba_pkg::class_words(c)) <= MAP_WORDS))
        begin
            r = bba_pkg::ALL_ONES >> bba_pkg::class_tail_shift(c);
        end
        else
        begin
            r = bba_pkg::ALL_ONES;
        end
        return r;
    endfunction

    // map storage
    logic [31:0] mem [MAP_WORDS];
    logic [31:0] rd_data_reg;

    // configuration
    logic [2:0]                size_class_reg;
    logic [bba_pkg::CFG_W-1:0] page_number_reg;

    logic [63:0]      addr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] chk_ptr_reg;
    logic             chk_vld_reg;
    logic [PTR_W-1:0] fill_ptr_reg;
    logic [GW-1:0]    grant_idx_reg;
    logic [QW-1:0]    quot_reg;
    logic [2:0]       rem_reg;
    logic [DCW-1:0]   div_cnt_reg;
    bba_pkg::bba_rsp_t rsp_reg;

    logic [2:0]        cls;
    logic [PTR_W-1:0]  used;
    logic [CW-1:0]     eff;
    logic [63:0]       base;
    logic [64:0]       diff;
    logic [31:0]       avail;
    logic [4:0]        hit_bit;
    logic              scan_hit;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [31:0]       wr_word;
    logic [QW+IDX_W-1:0] quot_ext;
    logic [IDX_W-1:0]  free_word;
    logic [4:0]        free_bit;
    logic [3:0]        dvs;
    logic [3:0]        trial;
    logic              trial_ge;
    logic [6:0]        bs;
    logic [GW+6:0]     grant_off;
    logic [63:0]       granted_calc;

    assign cls  = size_class_reg;
    assign used = used_words(cls);
    assign eff  = eff_blocks(cls);
    assign base = (64'(page_number_reg) << PAGE_SHIFT) + 64'(bba_pkg::HEADER_BYTES)
                + 64'({used, 2'b00});
    assign diff = {1'b0, addr_reg} - {1'b0, base};

    // allocate scan: lowest free bit of the word read last cycle
    assign avail    = rd_data_reg & valid_mask(cls, PTR_W'(chk_ptr_reg));
    assign scan_hit = chk_vld_reg && (avail != '0);

    always_comb
    begin
        hit_bit = '0;
        for (int b = 31; b >= 0; b--)
        begin
            if (avail[b])
            begin
                hit_bit = 5'(b);
            end
        end
    end

    // block index and bit of a block being freed
    assign quot_ext  = (QW + IDX_W)'(quot_reg);
    assign free_word = quot_ext[5 +: IDX_W];
    assign free_bit  = quot_reg[4:0];

    // restoring divide by class + 1, one quotient bit per step
    assign dvs      = {1'b0, cls} + 4'd1;
    assign trial    = {rem_reg, quot_reg[QW-1]};
    assign trial_ge = (trial >= dvs);

    assign bs           = {dvs, 3'b000};
    assign grant_off    = (GW + 7)'(grant_idx_reg) * (GW + 7)'(bs);
    assign granted_calc = base + 64'(grant_off);

    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_hit   = scan_hit;
    assign sts.scan_miss  = chk_vld_reg && (avail == '0)
                          && (PTR_W'(chk_ptr_reg) + PTR_W'(1) == used);
    assign sts.page_ok    = ((addr_reg >> PAGE_SHIFT) == 64'(page_number_reg)) && !diff[64];
    assign sts.div_last   = (div_cnt_reg == DCW'(QW - 1));
    assign sts.id_ok      = (quot_reg < QW'(eff));
    assign sts.fill_last  = (fill_ptr_reg == PTR_W'(MAP_WORDS - 1));

    // single read port
    assign rd_en  = (cmd.scan_step && (rd_ptr_reg < used)) || cmd.free_rd;
    assign rd_idx = cmd.free_rd ? free_word : rd_ptr_reg[IDX_W-1:0];

    // single write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_word = '0;
        priority if (cmd.fill_step)
        begin
            wr_en   = 1'b1;
            wr_idx  = fill_ptr_reg[IDX_W-1:0];
            wr_word = valid_mask(cls, fill_ptr_reg);
        end
        else if (cmd.scan_step && scan_hit)
        begin
            wr_en   = 1'b1;
            wr_idx  = chk_ptr_reg;
            wr_word = rd_data_reg & ~(32'd1 << hit_bit);
        end
        else if (cmd.free_wr)
        begin
            wr_en   = 1'b1;
            wr_idx  = free_word;
            wr_word = rd_data_reg | (32'd1 << free_bit);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.fill_step && sts.fill_last)
        begin
            count_next = eff;
        end
        else if (cmd.grant)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (cmd.free_wr && (count_reg < eff))
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_class_reg  <= '0;
            page_number_reg <= '0;
            count_reg       <= '0;
            rd_ptr_reg      <= '0;
            chk_vld_reg     <= 1'b0;
            fill_ptr_reg    <= '0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bba_pkg::CFG_SIZE_CLASS:  size_class_reg  <= cfg_data[2:0];
                    bba_pkg::CFG_PAGE_NUMBER: page_number_reg <= cfg_data;
                    default:                  page_number_reg <= page_number_reg;
                endcase
            end
            count_reg <= count_next;
            if (cmd.scan_start)
            begin
                rd_ptr_reg  <= '0;
                chk_vld_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_ptr_reg  <= rd_ptr_reg + PTR_W'(1);
                chk_vld_reg <= rd_en;
            end
            if (cmd.fill_step)
            begin
                fill_ptr_reg <= sts.fill_last ? '0 : fill_ptr_reg + PTR_W'(1);
            end
            if (cmd.free_chk)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.ld_addr)
        begin
            addr_reg <= req.block_addr;
        end
        if (cmd.scan_step)
        begin
            chk_ptr_reg <= rd_ptr_reg[IDX_W-1:0];
            if (scan_hit)
            begin
                grant_idx_reg <= {chk_ptr_reg, hit_bit};
            end
        end
        if (cmd.free_chk)
        begin
            quot_reg <= diff[PAGE_SHIFT-1:3];
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[QW-2:0], trial_ge};
            rem_reg  <= trial_ge ? 3'(trial - dvs) : trial[2:0];
        end
        if (cmd.res_load)
        begin
            rsp_reg.status       <= cmd.res_status;
            rsp_reg.granted_addr <= cmd.res_grant ? granted_calc : '0;
            rsp_reg.free_left    <= count_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// File: design/bitmap_block_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core: fixed-size block allocator for one page
// steps: allocate scans map words up to the one holding the granted block, or all used
//   map words when no valid bit is free; free checks page and base, then divides for
//   the block index and checks it; reinit refills MAP_WORDS map words; an unused op or
//   zero count is answered from idle; one request in flight at a time, word-serial map scan
// reset: fill of the class-zero pattern, no request taken until it ends
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core #(
    parameter int PAGE_SHIFT = 12,
    parameter int MAP_WORDS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      req_valid,
    output logic                      req_stall,
    input  bba_pkg::bba_req_t         req,
    // response channel
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output bba_pkg::bba_rsp_t         rsp,
    // configuration writes, only while idle
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [bba_pkg::CFG_W-1:0] cfg_data
);

    // the controller walks each request through its steps:
    //   allocate: issue one map read per cycle, test the previous word,
    //             clear the lowest free bit on a hit, then form the address
    //   free:     page and base check, one divide bit per cycle for the
    //             block index, then, if in range, read-modify-write of the map word
    //   reinit:   write one map word per cycle from the class pattern
    // the response sits in a register, so a new request is taken in the
    // same cycle that the previous response is drained

    bba_pkg::bba_cmd_t cmd;
    bba_pkg::bba_sts_t sts;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.op),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // map memory, free count, config registers and response register
    bba_dp #(
        .PAGE_SHIFT (PAGE_SHIFT),
        .MAP_WORDS  (MAP_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule
